// ===== hdl/gcdn_pkg.sv =====
// Shared types, codes and mod-10 helpers for the GTIN check digit block.
// No dependencies; used by every module under hdl.
package gcdn_pkg;

  localparam int MAX_DIGITS_DEF = 31;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CHAR_W         = 8;
  localparam int CFG_W          = 5;
  localparam int STATUS_W       = 3;
  localparam int DIGIT_W        = 4;

  localparam logic [CFG_W-1:0]  CFG_LENGTH_RESET = 5'd13;
  localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE        = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_APPENDED    = 3'd0,
    STATUS_VERIFIED    = 3'd1,
    STATUS_NON_DIGIT   = 3'd2,
    STATUS_BAD_LENGTH  = 3'd3,
    STATUS_WRONG_CHECK = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NON_DIGIT  = 2'd0,
    KIND_BAD_LENGTH = 2'd1,
    KIND_APPEND     = 2'd2,
    KIND_VERIFY     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               n_odd;
    logic [DIGIT_W-1:0] even_sum;
    logic [DIGIT_W-1:0] odd_sum;
    logic [DIGIT_W-1:0] latest;
  } job_t;

  function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[DIGIT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] sub_mod10(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + 5'd10 - {1'b0, b};
    end
    return s[DIGIT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] check_of(input logic [DIGIT_W-1:0] triple,
                                                  input logic [DIGIT_W-1:0] single);
    logic [5:0] w;
    w = {2'b00, triple} * 6'd3 + {2'b00, single};
    if (w >= 6'd20) begin
      w = w - 6'd20;
    end
    if (w >= 6'd10) begin
      w = w - 6'd10;
    end
    if (w == 6'd0) begin
      return '0;
    end
    return 4'd10 - w[DIGIT_W-1:0];
  endfunction

endpackage

// ===== hdl/gcdn_queue.sv =====
// Two-entry job queue between the character front and the result back.
// Depends on gcdn_pkg for job_t and QUEUE_DEPTH.
module gcdn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gcdn_pkg::job_t push_job,
  input  logic          pop,
  output gcdn_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);
  import gcdn_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign empty    = (fill_r == '0);
  assign full     = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign head_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/gcdn_front.sv =====
// Character front: classifies each byte, keeps the parity sums and length count,
// and on the last character pushes a classified job. Depends on gcdn_pkg.
module gcdn_front #(
  parameter int MAX_DIGITS = gcdn_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gcdn_pkg::CHAR_W-1:0]  in_character,
  input  logic                         in_last,
  input  logic [gcdn_pkg::CFG_W-1:0]   complete_length,
  input  logic                         queue_full,
  output logic                         push,
  output gcdn_pkg::job_t               push_job
);
  import gcdn_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [DIGIT_W-1:0] even_r, even_nxt;
  logic [DIGIT_W-1:0] odd_r, odd_nxt;
  logic [DIGIT_W-1:0] latest_r, latest_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               saw_nd_r, saw_nd_nxt;

  logic               accept;
  logic               is_digit;
  logic [CHAR_W-1:0]  diff;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] even_upd, odd_upd, latest_upd;
  logic [CW-1:0]      count_upd;
  logic               saw_nd_upd;
  logic [CW:0]        n_ext, n_plus, tgt_ext;
  kind_t              kind;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && in_last;

  always_comb begin
    is_digit   = (in_character >= CHAR_ZERO) && (in_character <= CHAR_NINE);
    diff       = in_character - CHAR_ZERO;
    digit      = diff[DIGIT_W-1:0];
    even_upd   = (is_digit && !count_r[0]) ? add_mod10(even_r, digit) : even_r;
    odd_upd    = (is_digit && count_r[0])  ? add_mod10(odd_r, digit)  : odd_r;
    latest_upd = is_digit ? digit : latest_r;
    saw_nd_upd = saw_nd_r || !is_digit;
    count_upd  = (count_r < CW'(MAX_DIGITS)) ? count_r + 1'b1 : count_r;

    n_ext   = {1'b0, count_upd};
    n_plus  = n_ext + 1'b1;
    tgt_ext = (CW + 1)'(complete_length);

    if (saw_nd_upd) begin
      kind = KIND_NON_DIGIT;
    end else if (complete_length < CFG_W'(2) || count_upd >= CW'(MAX_DIGITS)) begin
      kind = KIND_BAD_LENGTH;
    end else if (n_plus == tgt_ext) begin
      kind = KIND_APPEND;
    end else if (n_ext == tgt_ext) begin
      kind = KIND_VERIFY;
    end else begin
      kind = KIND_BAD_LENGTH;
    end

    push_job.kind     = kind;
    push_job.n_odd    = count_upd[0];
    push_job.even_sum = even_upd;
    push_job.odd_sum  = odd_upd;
    push_job.latest   = latest_upd;

    even_nxt   = even_r;
    odd_nxt    = odd_r;
    latest_nxt = latest_r;
    count_nxt  = count_r;
    saw_nd_nxt = saw_nd_r;
    if (accept) begin
      latest_nxt = latest_upd;
      if (in_last) begin
        even_nxt   = '0;
        odd_nxt    = '0;
        count_nxt  = '0;
        saw_nd_nxt = 1'b0;
      end else begin
        even_nxt   = even_upd;
        odd_nxt    = odd_upd;
        count_nxt  = count_upd;
        saw_nd_nxt = saw_nd_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_r   <= '0;
      odd_r    <= '0;
      latest_r <= '0;
      count_r  <= '0;
      saw_nd_r <= 1'b0;
    end else begin
      even_r   <= even_nxt;
      odd_r    <= odd_nxt;
      latest_r <= latest_nxt;
      count_r  <= count_nxt;
      saw_nd_r <= saw_nd_nxt;
    end
  end

endmodule

// ===== hdl/gcdn_back.sv =====
// Result back: pops a classified job, computes the check digit and status,
// and holds the result in the output register. Depends on gcdn_pkg.
module gcdn_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gcdn_pkg::job_t                head_job,
  input  logic                          queue_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcdn_pkg::STATUS_W-1:0] out_status,
  output logic [gcdn_pkg::DIGIT_W-1:0]  out_check_digit
);
  import gcdn_pkg::*;

  logic               valid_r, valid_nxt;
  status_t            status_r, status_nxt;
  logic [DIGIT_W-1:0] check_r, check_nxt;

  logic [DIGIT_W-1:0] se, so, calc;
  status_t            status_c;
  logic [DIGIT_W-1:0] check_c;

  assign pop = !queue_empty && (!valid_r || !out_stall);

  always_comb begin
    se       = head_job.even_sum;
    so       = head_job.odd_sum;
    calc     = '0;
    status_c = STATUS_BAD_LENGTH;
    check_c  = '0;
    case (head_job.kind)
      KIND_NON_DIGIT: begin
        status_c = STATUS_NON_DIGIT;
      end
      KIND_BAD_LENGTH: begin
        status_c = STATUS_BAD_LENGTH;
      end
      KIND_APPEND: begin
        calc     = head_job.n_odd ? check_of(se, so) : check_of(so, se);
        status_c = STATUS_APPENDED;
        check_c  = calc;
      end
      KIND_VERIFY: begin
        if (head_job.n_odd) begin
          se = sub_mod10(head_job.even_sum, head_job.latest);
        end else begin
          so = sub_mod10(head_job.odd_sum, head_job.latest);
        end
        calc = head_job.n_odd ? check_of(so, se) : check_of(se, so);
        if (calc == head_job.latest) begin
          status_c = STATUS_VERIFIED;
          check_c  = calc;
        end else begin
          status_c = STATUS_WRONG_CHECK;
        end
      end
      default: begin
        status_c = STATUS_BAD_LENGTH;
      end
    endcase

    valid_nxt  = valid_r && out_stall;
    status_nxt = status_r;
    check_nxt  = check_r;
    if (pop) begin
      valid_nxt  = 1'b1;
      status_nxt = status_c;
      check_nxt  = check_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    check_r  <= check_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_check_digit = check_r;

endmodule

// ===== hdl/gtin_check_digit_normalize.sv =====
// Top level of the streaming GTIN mod-10 check digit appender and verifier.
// Depends on gcdn_pkg, gcdn_front, gcdn_queue and gcdn_back.
//
// Usage:
//   Input channel: one ASCII byte per word on in_character, in_last marking the
//   final byte of a GTIN. A word is taken when in_valid is high and in_stall low.
//   Output channel: one word per GTIN on out_status / out_check_digit, taken
//   when out_valid is high and out_stall low.
//   Config: cfg_wr_en writes cfg_wr_data into the full GTIN length (reset 13);
//   write only while no GTIN is in flight.
//   Throughput: one character per cycle while in_stall is low, one result per
//   cycle while out_stall is low. The edge that takes the last character writes
//   its job into the queue; the job then loads the output register, raising out_valid.
//   A two-entry queue sits between the character front and the result back;
//   when out_stall holds the output register, the queue fills and then
//   in_stall rises until a result is taken.
//   Reset: clears the sums, the length count, the queue and the output valid,
//   and restores the length register to 13.
module gtin_check_digit_normalize #(
  parameter int MAX_DIGITS = gcdn_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gcdn_pkg::CHAR_W-1:0]   in_character,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcdn_pkg::STATUS_W-1:0] out_status,
  output logic [gcdn_pkg::DIGIT_W-1:0]  out_check_digit,
  input  logic                          cfg_wr_en,
  input  logic [gcdn_pkg::CFG_W-1:0]    cfg_wr_data
);
  import gcdn_pkg::*;

  logic [CFG_W-1:0] complete_length_r;
  logic             push, pop, queue_empty, queue_full;
  job_t             push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complete_length_r <= CFG_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      complete_length_r <= cfg_wr_data;
    end
  end

  gcdn_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_last        (in_last),
    .complete_length(complete_length_r),
    .queue_full     (queue_full),
    .push           (push),
    .push_job       (push_job)
  );

  gcdn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .empty   (queue_empty),
    .full    (queue_full)
  );

  gcdn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .queue_empty    (queue_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_check_digit(out_check_digit)
  );

endmodule

// ===== verif/tb_gtin_check_digit_normalize.sv =====
// Testbench for gtin_check_digit_normalize: directed GTIN table, then random GTIN streams
// checked against a mod-10 predictor under several length settings and idle patterns.
// Depends on gcdn_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module tb_gtin_check_digit_normalize;
  import gcdn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t            st;
    logic [DIGIT_W-1:0] cd;
  } gtin_result_t;

  typedef struct packed {
    logic [CFG_W-1:0]   cfg;
    logic [2:0]         len;
    logic [0:3][7:0]    ch;
    bit                 known;
    status_t            st;
    logic [DIGIT_W-1:0] cd;
  } gtin_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CHAR_W-1:0]   in_character;
  logic                in_last;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [DIGIT_W-1:0]  out_check_digit;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  gtin_result_t expected_results[$];
  int           mismatch_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_cycles = 0;

  bit                 exp_known = 0;
  status_t            exp_status = STATUS_APPENDED;
  logic [DIGIT_W-1:0] exp_cd = '0;

  logic [CFG_W-1:0]   len_setting = CFG_LENGTH_RESET;
  logic [DIGIT_W-1:0] acc_even = '0;
  logic [DIGIT_W-1:0] acc_odd = '0;
  logic [4:0]         acc_count = '0;
  logic [DIGIT_W-1:0] acc_latest = '0;
  bit                 acc_non_digit = 0;

  gtin_row_t dir_rows [18];
  int        cfg_plan [9] = '{13, 2, 31, 8, 18, 0, 2, 14, 1};
  int        budget_plan [9] = '{200, 120, 40, 200, 120, 30, 120, 200, 30};

  gtin_check_digit_normalize dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_check_digit(out_check_digit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DIGIT_W-1:0] weighted_check(int plen, int se, int so);
    int triple;
    int single;
    int w;
    triple = ((plen - 1) & 1) ? so : se;
    single = ((plen - 1) & 1) ? se : so;
    w = (3 * triple + single) % 10;
    return DIGIT_W'((10 - w) % 10);
  endfunction

  task automatic apply_char(input logic [7:0] ch, input bit last, output bit emits,
                            output gtin_result_t r);
    int d;
    int pos;
    int n;
    int tgt;
    int se;
    int so;
    logic [DIGIT_W-1:0] c;
    pos = int'(acc_count);
    emits = 0;
    r.st = STATUS_APPENDED;
    r.cd = '0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      d = int'(ch) - int'(CHAR_ZERO);
      acc_latest = DIGIT_W'(d);
      if (pos & 1) begin
        acc_odd = DIGIT_W'((int'(acc_odd) + d) % 10);
      end else begin
        acc_even = DIGIT_W'((int'(acc_even) + d) % 10);
      end
    end else begin
      acc_non_digit = 1;
    end
    if (acc_count < 5'(MAX_DIGITS_DEF)) begin
      acc_count = acc_count + 5'd1;
    end
    if (last) begin
      emits = 1;
      n = int'(acc_count);
      tgt = int'(len_setting);
      if (acc_non_digit) begin
        r.st = STATUS_NON_DIGIT;
      end else if (tgt < 2 || n >= MAX_DIGITS_DEF) begin
        r.st = STATUS_BAD_LENGTH;
      end else if (n == tgt - 1) begin
        r.st = STATUS_APPENDED;
        r.cd = weighted_check(n, int'(acc_even), int'(acc_odd));
      end else if (n == tgt) begin
        se = int'(acc_even);
        so = int'(acc_odd);
        if ((n - 1) & 1) begin
          so = (so + 10 - int'(acc_latest)) % 10;
        end else begin
          se = (se + 10 - int'(acc_latest)) % 10;
        end
        c = weighted_check(n - 1, se, so);
        if (c == acc_latest) begin
          r.st = STATUS_VERIFIED;
          r.cd = c;
        end else begin
          r.st = STATUS_WRONG_CHECK;
        end
      end else begin
        r.st = STATUS_BAD_LENGTH;
      end
      acc_even = '0;
      acc_odd = '0;
      acc_count = '0;
      acc_non_digit = 0;
    end
  endtask

  always @(posedge clk) begin
    bit           emits;
    gtin_result_t r;
    gtin_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, check_digit %0d", out_status,
                 out_check_digit);
          mismatch_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.st) begin
            $error("status: expected %0d, actual %0d", e.st, out_status);
            mismatch_count++;
          end
          if (out_check_digit !== e.cd) begin
            $error("check_digit: expected %0d, actual %0d", e.cd, out_check_digit);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_char(in_character, in_last, emits, r);
        if (emits) begin
          if (exp_known) begin
            r.st = exp_status;
            r.cd = exp_cd;
          end
          expected_results.push_back(r);
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("gtin_check_digit_normalize test failed");
    $finish;
  end

  function automatic gtin_row_t dir_row(logic [CFG_W-1:0] cfg, int len, logic [31:0] ch,
                                        bit known, status_t st, logic [DIGIT_W-1:0] cd);
    gtin_row_t row;
    row.cfg = cfg;
    row.len = 3'(len);
    row.ch = ch;
    row.known = known;
    row.st = st;
    row.cd = cd;
    return row;
  endfunction

  task automatic send_word(input logic [7:0] ch, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    len_setting = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] random_non_digit();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  task automatic send_random_gtin(output int sent);
    logic [7:0] chars[$];
    int kind;
    int n;
    int tgt;
    int sum;
    int i;
    logic [7:0] b;
    tgt = int'(len_setting);
    kind = $urandom_range(99);
    chars.delete();
    if (kind < 35) begin
      n = (tgt - 1 < 1) ? 1 : tgt - 1;
      for (i = 0; i < n; i++) chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    end else if (kind < 65) begin
      n = (tgt < 2) ? 2 : tgt;
      sum = 0;
      for (i = 0; i < n - 1; i++) begin
        b = 8'(CHAR_ZERO + $urandom_range(9));
        chars.push_back(b);
        sum += ((((n - 2) - i) % 2) == 0 ? 3 : 1) * (int'(b) - int'(CHAR_ZERO));
      end
      chars.push_back(8'(int'(CHAR_ZERO) + (10 - sum % 10) % 10));
    end else if (kind < 75) begin
      n = (tgt < 1) ? 1 : tgt;
      for (i = 0; i < n; i++) chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    end else if (kind < 85) begin
      n = tgt - $urandom_range(1);
      if (n < 1) n = 1;
      for (i = 0; i < n; i++) chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
      chars[$urandom_range(n - 1)] = random_non_digit();
    end else if (kind < 95) begin
      n = $urandom_range(40, 1);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) begin
          chars.push_back(8'($urandom_range(255)));
        end else begin
          chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        end
      end
    end else begin
      n = $urandom_range(40, 1);
      for (i = 0; i < n; i++) chars.push_back(8'($urandom_range(255)));
    end
    for (i = 0; i < chars.size(); i++) send_word(chars[i], i == chars.size() - 1);
    sent = chars.size();
  endtask

  initial begin
    int r;
    int i;
    int p;
    int sent;
    int total;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_character = '0;
    in_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;

    dir_rows[0]  = dir_row(5'd13, 1, {"0", 24'd0}, 1, STATUS_BAD_LENGTH, 4'd0);
    dir_rows[1]  = dir_row(5'd13, 1, {"A", 24'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[2]  = dir_row(5'd13, 1, {8'h00, 24'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[3]  = dir_row(5'd13, 1, {8'hFF, 24'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[4]  = dir_row(5'd13, 1, {"/", 24'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[5]  = dir_row(5'd13, 1, {":", 24'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[6]  = dir_row(5'd2, 1, {"0", 24'd0}, 1, STATUS_APPENDED, 4'd0);
    dir_rows[7]  = dir_row(5'd2, 1, {"9", 24'd0}, 0, STATUS_APPENDED, 4'd0);
    dir_rows[8]  = dir_row(5'd2, 2, {"00", 16'd0}, 1, STATUS_VERIFIED, 4'd0);
    dir_rows[9]  = dir_row(5'd2, 2, {"01", 16'd0}, 1, STATUS_WRONG_CHECK, 4'd0);
    dir_rows[10] = dir_row(5'd2, 2, {"99", 16'd0}, 0, STATUS_APPENDED, 4'd0);
    dir_rows[11] = dir_row(5'd2, 2, {"9A", 16'd0}, 1, STATUS_NON_DIGIT, 4'd0);
    dir_rows[12] = dir_row(5'd2, 3, {"123", 8'd0}, 1, STATUS_BAD_LENGTH, 4'd0);
    dir_rows[13] = dir_row(5'd0, 1, {"5", 24'd0}, 1, STATUS_BAD_LENGTH, 4'd0);
    dir_rows[14] = dir_row(5'd1, 1, {"5", 24'd0}, 1, STATUS_BAD_LENGTH, 4'd0);
    dir_rows[15] = dir_row(5'd31, 1, {"7", 24'd0}, 1, STATUS_BAD_LENGTH, 4'd0);
    dir_rows[16] = dir_row(5'd3, 2, {"12", 16'd0}, 0, STATUS_APPENDED, 4'd0);
    dir_rows[17] = dir_row(5'd3, 3, {"123", 8'd0}, 0, STATUS_APPENDED, 4'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 11;
    rx_idle_pct = 82;
    for (r = 0; r < 18; r++) begin
      if (dir_rows[r].cfg != len_setting) set_length(dir_rows[r].cfg);
      exp_known = dir_rows[r].known;
      exp_status = dir_rows[r].st;
      exp_cd = dir_rows[r].cd;
      for (i = 0; i < dir_rows[r].len; i++) begin
        send_word(dir_rows[r].ch[i], i == dir_rows[r].len - 1);
      end
    end
    exp_known = 0;

    for (p = 0; p < 9; p++) begin
      set_length(CFG_W'(cfg_plan[p]));
      if (p == 3) begin
        tx_idle_pct = 82;
        rx_idle_pct = 11;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
      end
      total = 0;
      while (total < budget_plan[p]) begin
        send_random_gtin(sent);
        total += sent;
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("gtin_check_digit_normalize test passed");
    end else begin
      $display("gtin_check_digit_normalize test failed");
    end
    $finish;
  end

endmodule
